@@ hdl/sida_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
package sida_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  // ascii codes, low six bits
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // bcd digit threshold and correction for the shift and add-3 step
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } sida_state_e;

endpackage

@@ hdl/signed_int_to_decimal_ascii.sv @@
// top level: signed integer to decimal ascii text, one character per transaction
//
// input channel: in_valid_i / in_ready_o carry one two's complement value_i.
// output channel: out_valid_o / out_ready_i carry one ascii character per
// transaction, most significant first, a leading '-' for negative values and
// last_char_o set on the final digit. zero gives "0"; no leading zeros.
// in_ready_o is high only while the sequencer is idle; a new value may be
// taken while the final character still sits in the output register.
// per value: the accept, the conversion through the shared shift and add-3 unit
// with four magnitude bits folded in at a time, the suppressed leading zeros
// dropped until the leading digit is found, then one character sent per cycle
// while the receiver takes them.
// a stalled receiver holds the output register and the sequencer waits.
// reset empties the output register and returns the sequencer to idle.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sida_pkg::CHAR_W-1:0]   text_char_o,
  output logic                          last_char_o
);
  import sida_pkg::*;

  // magnitude padded to whole nibbles, four bits folded in per cycle
  localparam int unsigned STEPS    = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PAD_BITS = STEPS * DIGIT_W;
  localparam int unsigned CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned BCD_W    = MAX_DIGITS * DIGIT_W;
  localparam int unsigned DIG_W    = $clog2(MAX_DIGITS + 1);

  sida_state_e state_q, state_d;

  logic [PAD_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d, bcd_step;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIG_W-1:0]    rem_q, rem_d;
  logic                neg_q, neg_d;

  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   text_char_q, text_char_d;
  logic                last_char_q, last_char_d;

  logic                in_accept;
  logic                slot_free;
  logic [DIGIT_W-1:0]  top_digit;
  logic                last_digit;
  logic [VALUE_BITS-1:0] mag_in;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  // output register is free when empty or being drained this cycle
  assign slot_free  = !out_valid_q || out_ready_i;
  assign top_digit  = bcd_q[BCD_W-1 -: DIGIT_W];
  assign last_digit = (rem_q == DIG_W'(1));

  // unsigned magnitude, correct for the most negative value too
  assign mag_in = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;

  sida_bcd_step #(
    .NUM_DIGITS (MAX_DIGITS)
  ) u_bcd_step (
    .bcd_i    (bcd_q),
    .nibble_i (mag_q[PAD_BITS-1 -: DIGIT_W]),
    .bcd_o    (bcd_step)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_q == '0) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        // stop at the first non-zero digit, always keep one digit
        if (last_digit || (top_digit != '0)) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && last_digit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register loads
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    text_char_d = text_char_q;
    last_char_d = last_char_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mag_d = PAD_BITS'(mag_in);
          bcd_d = '0;
          cnt_d = CNT_W'(STEPS - 1);
          rem_d = DIG_W'(MAX_DIGITS);
          neg_d = value_i[VALUE_BITS-1];
        end
      end
      ST_CONV: begin
        bcd_d = bcd_step;
        mag_d = mag_q << DIGIT_W;
        cnt_d = cnt_q - CNT_W'(1);
      end
      ST_SKIP: begin
        if (!last_digit && (top_digit == '0)) begin
          bcd_d = bcd_q << DIGIT_W;
          rem_d = rem_q - DIG_W'(1);
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          text_char_d = ASCII_MINUS;
          last_char_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          text_char_d = ASCII_ZERO + CHAR_W'(top_digit);
          last_char_d = last_digit;
          bcd_d       = bcd_q << DIGIT_W;
          rem_d       = rem_q - DIG_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    bcd_q       <= bcd_d;
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    text_char_q <= text_char_d;
    last_char_q <= last_char_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = text_char_q;
  assign last_char_o = last_char_q;

`ifndef SYNTHESIS
  // the final character of a number is always a digit
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> text_char_o != ASCII_MINUS)
    else $error("last character is a minus sign");

  // the digit counter never runs out while digits are still being sent
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SKIP) |-> rem_q != '0)
    else $error("digit counter empty while emitting");

  // every character shown is a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> text_char_o == ASCII_MINUS ||
                    (text_char_o >= ASCII_ZERO && text_char_o <= ASCII_ZERO + CHAR_W'(9)))
    else $error("character outside the decimal set");

  // a newly taken value keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a transaction");
`endif

endmodule

@@ hdl/sida_bcd_step.sv @@
// shift and add-3 unit: folds four magnitude bits into a packed bcd word
module sida_bcd_step #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*sida_pkg::DIGIT_W-1:0] bcd_i,
  input  logic [sida_pkg::DIGIT_W-1:0]            nibble_i,
  output logic [NUM_DIGITS*sida_pkg::DIGIT_W-1:0] bcd_o
);
  import sida_pkg::*;

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

  always_comb begin
    logic [BCD_W-1:0] acc;
    acc = bcd_i;
    // one bit at a time, most significant bit of the nibble first
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[d*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
          acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
        end
      end
      // carry out of the top digit is dropped: keeps the value modulo 10^digits
      acc = {acc[BCD_W-2:0], nibble_i[b]};
    end
    bcd_o = acc;
  end

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the signed integer to decimal ascii text converter

import sida_pkg::*;

// expected characters of every accepted value, oldest first, and the checks against them
class decimal_text_board #(int unsigned VALUE_BITS = 32, int unsigned MAX_DIGITS = 10);

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } text_char_t;

  text_char_t  pending_chars[$];
  int unsigned mismatches;
  int unsigned values_taken;
  int unsigned negatives_taken;
  int unsigned chars_checked;
  int unsigned longest_text;

  function new();
    mismatches      = 0;
    values_taken    = 0;
    negatives_taken = 0;
    chars_checked   = 0;
    longest_text    = 0;
  endfunction

  function int unsigned pending();
    return pending_chars.size();
  endfunction

  // decimal text of one accepted value, built on the unsigned magnitude
  function void queue_text_of(logic signed [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    logic [DIGIT_W-1:0]    digits[$];
    logic                  negative;
    text_char_t            one_char;
    int                    chars_before;

    negative  = value[VALUE_BITS-1];
    magnitude = negative ? ~value + 1'b1 : value;
    chars_before = pending_chars.size();

    // least significant digit first, always at least one digit
    do begin
      digits.push_back(DIGIT_W'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0 && digits.size() < MAX_DIGITS);

    // a magnitude cut to the digit buffer keeps no leading zeros
    while (digits.size() > 1 && digits[$] == 0) void'(digits.pop_back());

    if (negative) begin
      one_char.text_char = ASCII_MINUS;
      one_char.last_char = 1'b0;
      pending_chars.push_back(one_char);
      negatives_taken++;
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      one_char.text_char = CHAR_W'(ASCII_ZERO + digits[i]);
      one_char.last_char = (i == 0);
      pending_chars.push_back(one_char);
    end

    values_taken++;
    if (pending_chars.size() - chars_before > longest_text)
      longest_text = pending_chars.size() - chars_before;
  endfunction

  function void compare_char(logic [CHAR_W-1:0] text_char, logic last_char);
    text_char_t wanted;

    chars_checked++;
    if (pending_chars.size() == 0) begin
      $error("text_char: expected none, got %0d (last_char %0b)", text_char, last_char);
      mismatches++;
      return;
    end
    wanted = pending_chars.pop_front();
    if (text_char !== wanted.text_char) begin
      $error("text_char: expected %0d, got %0d", wanted.text_char, text_char);
      mismatches++;
    end
    if (last_char !== wanted.last_char) begin
      $error("last_char: expected %0b, got %0b", wanted.last_char, last_char);
      mismatches++;
    end
  endfunction

endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned MAX_DIGITS  = 10;
  // worst case is far below this: ~470 values, 11 characters each, random receiver stalls
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // a receiver hold-off well beyond what the single output register can absorb
  localparam int unsigned HOLD_CYCLES = 400;
  // settle time after the last character, longer than one full conversion
  localparam int unsigned TAIL_CYCLES = 40;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value     = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [CHAR_W-1:0]            text_char;
  logic                         last_char;

  decimal_text_board #(VALUE_BITS, MAX_DIGITS) board;

  // idling switches, changed per stimulus block by the main sequence
  bit tx_idle_on   = 1'b0;
  bit rx_idle_on   = 1'b0;
  // one-shot request for the long receiver hold-off
  bit rx_hold_req  = 1'b0;
  bit hold_done    = 1'b0;
  bit drain_done   = 1'b0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .text_char_o (text_char),
    .last_char_o (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard: a hung handshake ends the run here
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // one input transaction; entered and left at a falling edge with valid still high,
  // so the next call either keeps valid up or drops it, never both in one step
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.queue_text_of(v);
    @(negedge clk);
  endtask

  // sender goes quiet until every expected character has been taken
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // random values spread over every digit count, both signs and the extremes
  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic signed [VALUE_BITS-1:0] v;
    longint                       lo;
    longint                       hi;
    int unsigned                  n;

    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: begin
        // uniform over the number of digits
        n  = $urandom_range(1, MAX_DIGITS);
        lo = (n == 1) ? 0 : 64'd10 ** (n - 1);
        hi = 64'd10 ** n - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        v  = $urandom_range(int'(hi), int'(lo));
      end
      3: begin
        // one either side of a power of ten, where the digit count changes
        n = $urandom_range(0, MAX_DIGITS - 1);
        v = VALUE_BITS'(64'd10 ** n) + $urandom_range(0, 2) - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2:       v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
          default: v = -1;
        endcase
      end
    endcase
    // random sign for every non-negative value drawn
    if (v[VALUE_BITS-1] == 1'b0 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // output side: per character stall draw, plus the one long hold-off
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready   <= 1'b0;
        rx_hold_req  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (rx_idle_on) begin
        stall = $urandom_range(0, 16);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.compare_char(text_char, last_char);
      @(negedge clk);
    end
  end

  // main sequence
  initial begin
    logic signed [VALUE_BITS-1:0] directed[$];

    board = new();

    // reset held, released away from the rising edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero, one and two, single digits, sign boundaries, digit count steps
    // and both ends of the range including the most negative value
    directed = '{
      0, 1, 2, -1, -2, 5, -5, 9, 10, -10, 99, 100, -101,
      123456789, 999999999, -999999999, 1000000000, -1000000000,
      32'h7fffffff, 32'h80000000, 32'h80000001, 32'h7ffffffe,
      32'h55555555, 32'haaaaaaaa
    };
    foreach (directed[i]) send_value(directed[i]);
    drain_pause();

    // random blocks, walking through every idling combination
    for (int blk = 0; blk < 9; blk++) begin
      tx_idle_on = blk[0];
      rx_idle_on = blk[1];
      if (blk == 3) begin
        // receiver stops while the sender keeps offering back to back
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
      end
      for (int j = 0; j < 50; j++) send_value(random_value());
      if (blk == 5) begin
        drain_pause();
        drain_done = 1'b1;
      end
    end

    // end of stimulus: wait for every character, then a settle period
    drain_pause();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("converted %0d values (%0d negative) into %0d checked characters, longest text %0d",
             board.values_taken, board.negatives_taken, board.chars_checked,
             board.longest_text);
    $display("long output hold-off %0s, full drain pause %0s",
             hold_done ? "seen" : "missed", drain_done ? "seen" : "missed");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
